/* hdl/iir_bp_pkg.sv */
// Shared types, constants and coefficient functions of the band-pass filter.
package iir_bp_pkg;

    localparam int HIST_DEPTH = 10;
    localparam int IDX_W      = 4;
    localparam int X_W        = 32;
    localparam int Y_W        = 40;
    localparam int FF_W       = 38;
    localparam int HALF_W     = 20;
    localparam int OUT_FRAC   = 16;
    localparam int Q_W        = Y_W + 1 - OUT_FRAC;
    localparam int STEP_W     = 5;
    localparam int TABLE_FRAC = 28;

    localparam logic signed [63:0] INV_GAIN_Q28 = 64'sd95070224;

    localparam logic [STEP_W-1:0] STEP_START     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_X_ROUND   = 5'd1;
    localparam logic [STEP_W-1:0] STEP_AGE1      = 5'd1;
    localparam logic [STEP_W-1:0] STEP_AGE3      = 5'd2;
    localparam logic [STEP_W-1:0] STEP_AGE5      = 5'd3;
    localparam logic [STEP_W-1:0] STEP_AGE7      = 5'd4;
    localparam logic [STEP_W-1:0] STEP_AGE9      = 5'd5;
    localparam logic [STEP_W-1:0] STEP_ADD_XN    = 5'd6;
    localparam logic [STEP_W-1:0] STEP_XRD_LAST  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_YRD_LAST  = 5'd18;
    localparam logic [STEP_W-1:0] STEP_MUL_FIRST = 5'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_LAST  = 5'd20;
    localparam logic [STEP_W-1:0] STEP_ADD_FF    = 5'd22;
    localparam logic [STEP_W-1:0] STEP_ROUND     = 5'd23;
    localparam logic [STEP_W-1:0] STEP_LAST      = 5'd24;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } eng_state_t;

    typedef struct packed {
        logic             clear;
        logic             mul_en;
        logic             hi_half;
        logic [IDX_W-1:0] tap;
        logic             acc_ff;
        logic             fin;
    } mac_ctl_t;

    // Feedback coefficients in Q4.28, tap 0 applies to the oldest output.
    function automatic logic signed [63:0] fb_coef_q28(input logic [IDX_W-1:0] tap);
        logic signed [63:0] c;
        case (tap)
            4'd0:    c = 64'sd33670026;
            4'd1:    c = 64'sd34513125;
            4'd2:    c = -64'sd217605994;
            4'd3:    c = -64'sd205742779;
            4'd4:    c = 64'sd586429137;
            4'd5:    c = 64'sd486047453;
            4'd6:    c = -64'sd844632474;
            4'd7:    c = -64'sd547393357;
            4'd8:    c = 64'sd667705511;
            4'd9:    c = 64'sd275121446;
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

    // Moves a Q28 constant to frac fraction bits, rounding half up when narrowing.
    function automatic logic signed [63:0] rescale_q28(input logic signed [63:0] q,
                                                       input int frac);
        logic signed [63:0] r;
        if (frac >= TABLE_FRAC)
        begin
            r = q <<< (frac - TABLE_FRAC);
        end
        else
        begin
            r = (q + (64'sd1 <<< (TABLE_FRAC - 1 - frac))) >>> (TABLE_FRAC - frac);
        end
        return r;
    endfunction

endpackage

/* hdl/iir_bp_hist.sv */
// Ten-entry circular history memory with registered read by sample age.
module iir_bp_hist #(
    parameter int WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [iir_bp_pkg::IDX_W-1:0]   rd_age,
    output logic [WIDTH-1:0]               rd_data
);
    import iir_bp_pkg::*;

    logic [WIDTH-1:0] mem_reg [HIST_DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] fill_next;
    logic [IDX_W:0]   rd_sum;
    logic [IDX_W-1:0] rd_addr;

    // Entries that were never written read as zero through the fill count.
    always_comb
    begin
        rd_sum = {1'b0, wr_ptr_reg} + (IDX_W + 1)'(HIST_DEPTH - 1) - {1'b0, rd_age};
        if (rd_sum >= (IDX_W + 1)'(HIST_DEPTH))
        begin
            rd_sum = rd_sum - (IDX_W + 1)'(HIST_DEPTH);
        end
        rd_addr       = rd_sum[IDX_W-1:0];
        rd_valid_next = rd_valid_reg;
        if (rd_en)
        begin
            rd_valid_next = (rd_age < fill_reg);
        end
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en)
        begin
            if (wr_ptr_reg == IDX_W'(HIST_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
            if (fill_reg != IDX_W'(HIST_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hdl/iir_bp_mac.sv */
// Shared multiply-accumulate unit for the feedback sum, rounding and saturation.
module iir_bp_mac #(
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iir_bp_pkg::mac_ctl_t                  ctl,
    input  logic [iir_bp_pkg::Y_W-1:0]            y_op,
    input  logic signed [iir_bp_pkg::FF_W-1:0]    ff,
    output logic signed [iir_bp_pkg::Y_W-1:0]     y
);
    import iir_bp_pkg::*;

    localparam int CW    = COEF_FRAC_BITS + 3;
    localparam int PRW   = CW + HALF_W + 1;
    localparam int ACC_W = COEF_FRAC_BITS + 48;
    localparam int SH_W  = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SH_W-1:0]  Y_MAX   = SH_W'((64'sd1 <<< (Y_W - 1)) - 1);
    localparam logic signed [SH_W-1:0]  Y_MIN   = SH_W'(-(64'sd1 <<< (Y_W - 1)));

    logic signed [63:0]       coef_full;
    logic signed [CW-1:0]     coef;
    logic signed [HALF_W:0]   half;
    logic signed [PRW-1:0]    prod_reg;
    logic                     prod_hi_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [SH_W-1:0]   y_sh;
    logic signed [Y_W-1:0]    y_reg;
    logic signed [Y_W-1:0]    y_next;

    // The 40-bit history word is multiplied in two halves on successive cycles.
    always_comb
    begin
        coef_full = rescale_q28(fb_coef_q28(ctl.tap), COEF_FRAC_BITS);
        coef      = coef_full[CW-1:0];
        if (ctl.hi_half)
        begin
            half = {y_op[Y_W-1], y_op[Y_W-1:HALF_W]};
        end
        else
        begin
            half = {1'b0, y_op[HALF_W-1:0]};
        end
        prod_ext = ACC_W'(prod_reg);
        if (prod_hi_reg)
        begin
            prod_ext = prod_ext <<< HALF_W;
        end
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + prod_ext;
        end
        else if (ctl.acc_ff)
        begin
            acc_next = acc_reg + (ACC_W'(ff) <<< COEF_FRAC_BITS) + ROUND_C;
        end
        y_sh = acc_reg[ACC_W-1:COEF_FRAC_BITS];
        if (y_sh > Y_MAX)
        begin
            y_next = Y_MAX[Y_W-1:0];
        end
        else if (y_sh < Y_MIN)
        begin
            y_next = Y_MIN[Y_W-1:0];
        end
        else
        begin
            y_next = y_sh[Y_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg    <= PRW'(coef * half);
            prod_hi_reg <= ctl.hi_half;
        end
        acc_reg <= acc_next;
        if (ctl.fin)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

/* hdl/iir_bandpass_butterworth_order10.sv */
// Top level of the 10-pole band-pass filter: stream ports, sequencer and datapath.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[SAMPLE_WIDTH-1:0] = sample_in
//  m_axis    out        tdata[SAMPLE_WIDTH-1:0] = sample_out
//
// Each sample is processed in the engine by the one shared multiplier
// that forms twenty half-word products from the output history memory.
// A new sample is buffered while the previous one is processed, and the result
// register lets the engine work on the next sample while the downstream side is still busy.
// The engine stalls on its last step only while an earlier result waits.
// Reset clears both histories at once through their fill counts.
module iir_bandpass_butterworth_order10 #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Bits from the lowest: sample_in, then zero fill.
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Bits from the lowest: sample_out, then zero fill.
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata
);
    import iir_bp_pkg::*;

    localparam int IW   = COEF_FRAC_BITS + 1;
    localparam int PW   = SAMPLE_WIDTH + IW;
    localparam int XW   = (PW + 2 > X_W + 1) ? PW + 2 : X_W + 1;
    localparam int RS   = COEF_FRAC_BITS - 16;
    localparam logic signed [IW-1:0] INV_GAIN =
        IW'(rescale_q28(INV_GAIN_Q28, COEF_FRAC_BITS));
    localparam logic signed [XW-1:0] X_RND  = (RS == 0) ? XW'(0) : XW'(64'sd1 <<< (RS - 1));
    localparam logic signed [XW-1:0] X_MAX  = XW'((64'sd1 <<< (X_W - 1)) - 1);
    localparam logic signed [XW-1:0] X_MIN  = XW'(-(64'sd1 <<< (X_W - 1)));
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    eng_state_t               state_reg;
    eng_state_t               state_next;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        step_next;
    logic [STEP_W-1:0]        mul_idx;
    logic                     in_full_reg;
    logic                     in_full_next;
    logic [SAMPLE_WIDTH-1:0]  in_data_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [PW-1:0]     xp_reg;
    logic signed [XW-1:0]     x_full;
    logic signed [X_W-1:0]    xn_reg;
    logic signed [X_W-1:0]    xn_next;
    logic signed [FF_W-1:0]   ff_reg;
    logic signed [FF_W-1:0]   ff_next;
    logic signed [FF_W-1:0]   d1;
    logic signed [FF_W-1:0]   d5;
    logic signed [FF_W-1:0]   d10;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [SAMPLE_WIDTH-1:0]  out_data_reg;
    logic [SAMPLE_WIDTH-1:0]  q_sat;
    logic signed [Y_W:0]      q_adj;
    logic signed [Q_W-1:0]    q_val;
    logic                     running;
    logic                     take;
    logic                     done;
    logic                     out_free;
    logic                     load;
    logic                     hist_wr;
    logic                     xh_rd;
    logic [IDX_W-1:0]         xh_age;
    logic [X_W-1:0]           xh_data;
    logic                     yh_rd;
    logic [IDX_W-1:0]         yh_age;
    logic [Y_W-1:0]           yh_data;
    mac_ctl_t                 mac_ctl;
    logic signed [Y_W-1:0]    y_new;

    assign take     = s_axis_tvalid && !in_full_reg;
    assign running  = (state_reg == ST_RUN);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign done     = running && (step_reg == STEP_LAST);
    assign hist_wr  = done && out_free;
    assign load     = in_full_reg && (!running || hist_wr);
    assign mul_idx  = step_reg - STEP_MUL_FIRST;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        in_full_next = in_full_reg;
        if (take)
        begin
            in_full_next = 1'b1;
        end
        if (load)
        begin
            state_next   = ST_RUN;
            step_next    = STEP_START;
            in_full_next = 1'b0;
        end
        else if (hist_wr)
        begin
            state_next = ST_IDLE;
        end
        else if (running && !done)
        begin
            step_next = step_reg + 1'b1;
        end

        xh_rd  = running && (step_reg <= STEP_XRD_LAST);
        xh_age = {step_reg[IDX_W-2:0], 1'b1};
        yh_rd  = running && !step_reg[0] && (step_reg <= STEP_YRD_LAST);
        yh_age = IDX_W'(HIST_DEPTH - 1) - step_reg[IDX_W:1];

        mac_ctl.clear   = running && (step_reg == STEP_START);
        mac_ctl.mul_en  = running && (step_reg >= STEP_MUL_FIRST) &&
                          (step_reg <= STEP_MUL_LAST);
        mac_ctl.hi_half = mul_idx[0];
        mac_ctl.tap     = mul_idx[IDX_W:1];
        mac_ctl.acc_ff  = running && (step_reg == STEP_ADD_FF);
        mac_ctl.fin     = running && (step_reg == STEP_ROUND);

        x_full = (XW'(xp_reg) + X_RND) >>> RS;
        if (x_full > X_MAX)
        begin
            xn_next = X_MAX[X_W-1:0];
        end
        else if (x_full < X_MIN)
        begin
            xn_next = X_MIN[X_W-1:0];
        end
        else
        begin
            xn_next = x_full[X_W-1:0];
        end

        // Feed-forward taps of (1 - z^-2)^5 on the even-delayed inputs.
        d1      = FF_W'($signed(xh_data));
        d5      = (d1 <<< 2) + d1;
        d10     = d5 <<< 1;
        ff_next = ff_reg;
        if (running)
        begin
            case (step_reg)
                STEP_START:  ff_next = '0;
                STEP_AGE1:   ff_next = ff_reg - d5;
                STEP_AGE3:   ff_next = ff_reg + d10;
                STEP_AGE5:   ff_next = ff_reg - d10;
                STEP_AGE7:   ff_next = ff_reg + d5;
                STEP_AGE9:   ff_next = ff_reg - d1;
                STEP_ADD_XN: ff_next = ff_reg + FF_W'(xn_reg);
                default:     ff_next = ff_reg;
            endcase
        end

        q_adj = {y_new[Y_W-1], y_new};
        if (y_new[Y_W-1])
        begin
            q_adj = q_adj + (Y_W + 1)'((64'sd1 <<< OUT_FRAC) - 1);
        end
        q_val = q_adj[Y_W:OUT_FRAC];
        if (q_val > Q_MAX)
        begin
            q_sat = Q_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (q_val < Q_MIN)
        begin
            q_sat = Q_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            q_sat = q_val[SAMPLE_WIDTH-1:0];
        end

        out_valid_next = out_valid_reg;
        if (hist_wr)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        m_axis_tdata                   = '0;
        m_axis_tdata[SAMPLE_WIDTH-1:0] = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_START;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
        if (load)
        begin
            sample_reg <= $signed(in_data_reg);
        end
        if (running && (step_reg == STEP_START))
        begin
            xp_reg <= PW'(sample_reg * INV_GAIN);
        end
        if (running && (step_reg == STEP_X_ROUND))
        begin
            xn_reg <= xn_next;
        end
        ff_reg <= ff_next;
        if (hist_wr)
        begin
            out_data_reg <= q_sat;
        end
    end

    iir_bp_hist #(
        .WIDTH (X_W)
    ) u_x_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hist_wr),
        .wr_data (xn_reg),
        .rd_en   (xh_rd),
        .rd_age  (xh_age),
        .rd_data (xh_data)
    );

    iir_bp_hist #(
        .WIDTH (Y_W)
    ) u_y_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hist_wr),
        .wr_data (y_new),
        .rd_en   (yh_rd),
        .rd_age  (yh_age),
        .rd_data (yh_data)
    );

    iir_bp_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .y_op  (yh_data),
        .ff    (ff_reg),
        .y     (y_new)
    );

    assign s_axis_tready = !in_full_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule
